FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the escape sequence decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define C_ESC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, also while reset is applied.
`define C_ESC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/c_esc_pkg.sv
// Types, character codes and digit helpers of the escape sequence decoder.
`default_nettype none

package c_esc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX0 = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_OCT1 = 3'd4,
    MODE_OCT2 = 3'd5
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_X_LO      = 8'h78;
  localparam logic [7:0] CHAR_X_UP      = 8'h58;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_A_LO      = 8'h61;
  localparam logic [7:0] CHAR_F_LO      = 8'h66;
  localparam logic [7:0] CHAR_A_UP      = 8'h41;
  localparam logic [7:0] CHAR_F_UP      = 8'h46;
  localparam logic [7:0] CHAR_B_LO      = 8'h62;
  localparam logic [7:0] CHAR_N_LO      = 8'h6e;
  localparam logic [7:0] CHAR_R_LO      = 8'h72;
  localparam logic [7:0] CHAR_T_LO      = 8'h74;
  localparam logic [7:0] CHAR_V_LO      = 8'h76;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      t = b - CHAR_ZERO;
      return {1'b1, t[3:0]};
    end else if (b >= CHAR_A_LO && b <= CHAR_F_LO) begin
      t = b - CHAR_A_LO;
      return {1'b1, t[3:0] + 4'd10};
    end else if (b >= CHAR_A_UP && b <= CHAR_F_UP) begin
      t = b - CHAR_A_UP;
      return {1'b1, t[3:0] + 4'd10};
    end
    return 5'd0;
  endfunction

  // Returns {valid, digit value}.
  function automatic logic [3:0] oct_val(logic [7:0] b);
    if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
      return {1'b1, b[2:0]};
    end
    return 4'd0;
  endfunction

  // Returns {valid, control code} for the single letter escapes.
  function automatic logic [8:0] letter_val(logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    unique case (b)
      CHAR_A_LO: r = {1'b1, 8'd7};
      CHAR_B_LO: r = {1'b1, 8'd8};
      CHAR_F_LO: r = {1'b1, 8'd12};
      CHAR_N_LO: r = {1'b1, 8'd10};
      CHAR_R_LO: r = {1'b1, 8'd13};
      CHAR_T_LO: r = {1'b1, 8'd9};
      CHAR_V_LO: r = {1'b1, 8'd11};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/c_escape_sequence_decoder.sv
// Top level of the C string escape sequence decoder with its output queue.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   in      | input     | in_valid_i / in_ready_o  | in_byte_i, in_last_i
//   out     | output    | out_valid_o / out_ready_i| out_byte_o, out_last_o
//
// Each accepted word is decoded in the cycle it arrives and gives zero, one or two
// bytes, which are written into a four-entry output queue.
// The queue sends one byte per cycle while out_ready_i is high, so the input
// takes one word per cycle while it drains; a two-byte word can stall the input.
// Input ready is high while at least two queue entries are free.
// Reset empties the queue and returns the parser to idle.
`default_nettype none

`include "assert_macros.svh"

module c_escape_sequence_decoder (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] in_byte_i,
  input  wire        in_last_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  c_esc_pkg::mode_e mode_q, mode_d;
  logic [7:0]       pend_q, pend_d;
  logic             upx_q, upx_d;

  logic             idle_emit;
  c_esc_pkg::res_t  idle_res;
  c_esc_pkg::mode_e idle_mode;

  logic [1:0]       n_res;
  c_esc_pkg::res_t  res0, res1;

  logic [4:0]       hex;
  logic [3:0]       oct;
  logic [8:0]       letter;

  c_esc_pkg::res_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             in_fire, out_fire;
  logic             last_fire;
  logic [1:0]       n_push;

  assign in_fire   = in_valid_i & in_ready_o;
  assign out_fire  = out_valid_o & out_ready_i;
  assign last_fire = in_fire & in_last_i;

  assign hex    = c_esc_pkg::hex_val(in_byte_i);
  assign oct    = c_esc_pkg::oct_val(in_byte_i);
  assign letter = c_esc_pkg::letter_val(in_byte_i);

  always_comb begin
    idle_emit = 1'b1;
    idle_res  = '{data: in_byte_i, last: in_last_i};
    idle_mode = c_esc_pkg::MODE_IDLE;
    if (in_byte_i == c_esc_pkg::CHAR_BACKSLASH) begin
      if (in_last_i) begin
        idle_res = '{data: 8'h00, last: 1'b1};
      end else begin
        idle_emit = 1'b0;
        idle_mode = c_esc_pkg::MODE_ESC;
      end
    end
  end

  always_comb begin
    mode_d = c_esc_pkg::MODE_IDLE;
    pend_d = pend_q;
    upx_d  = upx_q;
    n_res  = 2'd0;
    res0   = idle_res;
    res1   = idle_res;
    unique case (mode_q)
      c_esc_pkg::MODE_ESC: begin
        if (letter[8]) begin
          n_res = 2'd1;
          res0  = '{data: letter[7:0], last: in_last_i};
        end else if (in_byte_i == c_esc_pkg::CHAR_X_LO ||
                     in_byte_i == c_esc_pkg::CHAR_X_UP) begin
          upx_d = (in_byte_i == c_esc_pkg::CHAR_X_UP);
          if (in_last_i) begin
            n_res = 2'd1;
            res0  = '{data: in_byte_i, last: 1'b1};
          end else begin
            mode_d = c_esc_pkg::MODE_HEX0;
          end
        end else if (oct[3]) begin
          pend_d = {5'd0, oct[2:0]};
          if (in_last_i) begin
            n_res = 2'd1;
            res0  = '{data: {5'd0, oct[2:0]}, last: 1'b1};
          end else begin
            mode_d = c_esc_pkg::MODE_OCT1;
          end
        end else begin
          n_res = 2'd1;
          res0  = '{data: in_byte_i, last: in_last_i};
        end
      end
      c_esc_pkg::MODE_HEX0: begin
        if (hex[4]) begin
          pend_d = {4'd0, hex[3:0]};
          if (in_last_i) begin
            n_res = 2'd1;
            res0  = '{data: {4'd0, hex[3:0]}, last: 1'b1};
          end else begin
            mode_d = c_esc_pkg::MODE_HEX1;
          end
        end else begin
          res0   = '{data: upx_q ? c_esc_pkg::CHAR_X_UP : c_esc_pkg::CHAR_X_LO, last: 1'b0};
          n_res  = idle_emit ? 2'd2 : 2'd1;
          mode_d = idle_mode;
        end
      end
      c_esc_pkg::MODE_HEX1: begin
        if (hex[4]) begin
          n_res = 2'd1;
          res0  = '{data: {pend_q[3:0], hex[3:0]}, last: in_last_i};
        end else begin
          res0   = '{data: pend_q, last: 1'b0};
          n_res  = idle_emit ? 2'd2 : 2'd1;
          mode_d = idle_mode;
        end
      end
      c_esc_pkg::MODE_OCT1: begin
        if (oct[3]) begin
          pend_d = {pend_q[4:0], oct[2:0]};
          if (in_last_i) begin
            n_res = 2'd1;
            res0  = '{data: {pend_q[4:0], oct[2:0]}, last: 1'b1};
          end else begin
            mode_d = c_esc_pkg::MODE_OCT2;
          end
        end else begin
          res0   = '{data: pend_q, last: 1'b0};
          n_res  = idle_emit ? 2'd2 : 2'd1;
          mode_d = idle_mode;
        end
      end
      c_esc_pkg::MODE_OCT2: begin
        if (oct[3]) begin
          n_res = 2'd1;
          res0  = '{data: {pend_q[4:0], oct[2:0]}, last: in_last_i};
        end else begin
          res0   = '{data: pend_q, last: 1'b0};
          n_res  = idle_emit ? 2'd2 : 2'd1;
          mode_d = idle_mode;
        end
      end
      default: begin
        n_res  = idle_emit ? 2'd1 : 2'd0;
        mode_d = idle_mode;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= c_esc_pkg::MODE_IDLE;
      pend_q <= 8'h00;
      upx_q  <= 1'b0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      upx_q  <= upx_d;
    end
  end

  assign n_push     = in_fire ? n_res : 2'd0;
  assign in_ready_o = (cnt_q <= CntW'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = mem_q[rd_ptr_q].data;
  assign out_last_o  = mem_q[rd_ptr_q].last;

  assign cnt_d = cnt_q + CntW'(n_push) - CntW'(out_fire);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_fire);
      cnt_q    <= cnt_d;
    end
  end

  `C_ESC_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "Queue count above depth.")
  `C_ESC_ASSERT(a_ptr_match, (wr_ptr_q - rd_ptr_q) == cnt_q[PtrW-1:0], "Queue pointers off.")
  `C_ESC_ASSERT(a_last_idle, last_fire |=> mode_q == c_esc_pkg::MODE_IDLE, "Parser not idle.")
  `C_ESC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "Output valid after reset.")

endmodule

`default_nettype wire
